// ===== rtl/core/smcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smcc_pkg: shared definitions of the solar charge controller
// Stage, event and action codes, register indexes, reset levels and the
// stage transition and action table.
// ----------------------------------------------------------------------------
package smcc_pkg;

  localparam int STAGE_W = 3;
  localparam int EVENT_W = 3;
  localparam int ACT_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W  = 8;

  localparam int DUTY_MAX_DEF    = 630;
  localparam int DUTY_MIN_DEF    = 10;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DUTY_RESET      = 320;
  localparam int STEP_CAP        = 64;

  localparam int VSOL_OK_RESET   = 776;
  localparam int VBAT_LOW_RESET  = 3240;
  localparam int VBAT_OK_RESET   = 3447;
  localparam int VBAT_HIGH_RESET = 4054;
  localparam int TOP_TGT_RESET   = 3916;
  localparam int FLT_TGT_RESET   = 3723;
  localparam int IBAT_LOW_RESET  = 81;

  localparam logic [STAGE_W-1:0] ST_START   = 3'd0;
  localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd1;
  localparam logic [STAGE_W-1:0] ST_MPPT    = 3'd2;
  localparam logic [STAGE_W-1:0] ST_TOPPING = 3'd3;
  localparam logic [STAGE_W-1:0] ST_FLOAT   = 3'd4;

  localparam logic [EVENT_W-1:0] EV_VBAT_LOW  = 3'd0;
  localparam logic [EVENT_W-1:0] EV_VBAT_OK   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_VBAT_HIGH = 3'd2;
  localparam logic [EVENT_W-1:0] EV_VSOL_LOW  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_VSOL_OK   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_IBAT_LOW  = 3'd5;
  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd6;

  localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_ON  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD_OFF = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PWM_ON   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PWM_OFF  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_VSOL_OK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VBAT_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VBAT_OK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VBAT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_TGT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLT_TGT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IBAT_LOW  = 3'd6;

  typedef struct packed {
    logic vb_ge_ok;
    logic vb_lt_low;
    logic vb_ge_high;
    logic vs_ge_ok;
    logic ib_lt_low;
  } cmp_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_code;
    logic [ACT_W-1:0]   act;
    logic [STAGE_W-1:0] next_stage;
  } decision_t;

  function automatic logic [ACT_W+STAGE_W-1:0] table_cell(
    input logic [STAGE_W-1:0] stage,
    input logic [EVENT_W-1:0] ev
  );
    logic [ACT_W+STAGE_W-1:0] c;
    c = {ACT_NONE, ST_START};
    unique case (stage)
      ST_IDLE: begin
        priority case (ev)
          EV_VBAT_LOW: c = {ACT_LOAD_OFF, ST_START};
          EV_VSOL_OK:  c = {ACT_PWM_ON, ST_MPPT};
          default:     c = {ACT_NONE, ST_IDLE};
        endcase
      end
      ST_MPPT: begin
        priority case (ev)
          EV_VBAT_LOW:  c = {ACT_LOAD_OFF, ST_MPPT};
          EV_VBAT_OK:   c = {ACT_LOAD_ON, ST_MPPT};
          EV_VBAT_HIGH: c = {ACT_NONE, ST_TOPPING};
          EV_VSOL_LOW:  c = {ACT_PWM_OFF, ST_IDLE};
          default:      c = {ACT_NONE, ST_MPPT};
        endcase
      end
      ST_TOPPING: begin
        priority case (ev)
          EV_VBAT_LOW: c = {ACT_LOAD_OFF, ST_MPPT};
          EV_VSOL_LOW: c = {ACT_PWM_OFF, ST_IDLE};
          EV_IBAT_LOW: c = {ACT_NONE, ST_FLOAT};
          default:     c = {ACT_NONE, ST_TOPPING};
        endcase
      end
      ST_FLOAT: begin
        priority case (ev)
          EV_VBAT_LOW: c = {ACT_LOAD_OFF, ST_MPPT};
          EV_VSOL_LOW: c = {ACT_PWM_OFF, ST_IDLE};
          default:     c = {ACT_NONE, ST_FLOAT};
        endcase
      end
      default: begin
        priority case (ev)
          EV_VBAT_OK: c = {ACT_LOAD_ON, ST_IDLE};
          EV_VSOL_OK: c = {ACT_PWM_ON, ST_MPPT};
          default:    c = {ACT_NONE, ST_START};
        endcase
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/solar_mppt_charge_controller_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// solar_mppt_charge_controller_unit: battery charge controller with MPPT
// Takes one averaged measurement set per transfer and returns the new
// charge stage, the chosen event, the PWM duty and the enable flags.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready) carries solar and battery voltage
//   and current. Result channel (result_valid/result_ready) returns stage,
//   event, duty, PWM and load enables and the limit flag, one per item.
//   Config channel (cfg_valid/cfg_ready) writes threshold registers by
//   cfg_index; cfg_ready is always high. Write only while the block is idle.
// Pipeline and throughput:
//   Three register stages: input capture, product register (incremental
//   conductance cross products), result register; an item passes all three
//   before its result is valid. One item per cycle while results are taken;
//   the stage, duty and enable feedback closes within the last stage.
// Reset:
//   Start stage, duty 320, PWM and load off, previous sample zero, all
//   thresholds at their defaults, pipeline empty.
// Stall:
//   When a result waits and result_ready is low the pipeline holds; item_ready
//   drops once all three stages are full.
// ----------------------------------------------------------------------------
module solar_mppt_charge_controller_unit #(
  parameter int DUTY_MAX    = smcc_pkg::DUTY_MAX_DEF,
  parameter int DUTY_MIN    = smcc_pkg::DUTY_MIN_DEF,
  parameter int SAMPLE_BITS = smcc_pkg::SAMPLE_BITS_DEF,
  localparam int W      = SAMPLE_BITS,
  localparam int DUTY_W = $clog2(DUTY_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [W-1:0]                  solar_voltage,
  input  logic [W-1:0]                  solar_current,
  input  logic [W-1:0]                  battery_voltage,
  input  logic [W-1:0]                  battery_current,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [smcc_pkg::STAGE_W-1:0]  charge_stage,
  output logic [smcc_pkg::EVENT_W-1:0]  event_code,
  output logic [DUTY_W-1:0]             duty_count,
  output logic                          pwm_enabled,
  output logic                          load_enabled,
  output logic                          limit_hit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [W-1:0]                  cfg_data
);

  localparam int PW = 2 * W + 2;
  localparam int SW = PW + 1;
  localparam int DW = DUTY_W + 2;
  localparam int SP = smcc_pkg::STEP_W;

  // configuration registers
  logic [W-1:0] vsol_ok_level, vbat_low_level, vbat_ok_level, vbat_high_level;
  logic [W-1:0] topping_target, float_target, ibat_low_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vsol_ok_level   <= W'(smcc_pkg::VSOL_OK_RESET);
      vbat_low_level  <= W'(smcc_pkg::VBAT_LOW_RESET);
      vbat_ok_level   <= W'(smcc_pkg::VBAT_OK_RESET);
      vbat_high_level <= W'(smcc_pkg::VBAT_HIGH_RESET);
      topping_target  <= W'(smcc_pkg::TOP_TGT_RESET);
      float_target    <= W'(smcc_pkg::FLT_TGT_RESET);
      ibat_low_level  <= W'(smcc_pkg::IBAT_LOW_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smcc_pkg::REG_VSOL_OK:   vsol_ok_level   <= cfg_data;
        smcc_pkg::REG_VBAT_LOW:  vbat_low_level  <= cfg_data;
        smcc_pkg::REG_VBAT_OK:   vbat_ok_level   <= cfg_data;
        smcc_pkg::REG_VBAT_HIGH: vbat_high_level <= cfg_data;
        smcc_pkg::REG_TOP_TGT:   topping_target  <= cfg_data;
        smcc_pkg::REG_FLT_TGT:   float_target    <= cfg_data;
        smcc_pkg::REG_IBAT_LOW:  ibat_low_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid, s2_valid;
  logic out_free, s1_adv, s2_adv, item_xfer;

  assign out_free   = !result_valid || result_ready;
  assign s2_adv     = s2_valid && out_free;
  assign s1_adv     = s1_valid && (!s2_valid || out_free);
  assign item_ready = !s1_valid || !s2_valid || out_free;
  assign item_xfer  = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_xfer)   s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv)      s2_valid <= 1'b1;
      else if (s2_adv) s2_valid <= 1'b0;
      if (s2_adv)            result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  // input capture and previous solar sample
  logic [W-1:0] prev_solar_voltage, prev_solar_current;
  logic [W-1:0] s1_vs, s1_is, s1_vb, s1_ib, s1_pvs, s1_pis;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_solar_voltage <= '0;
      prev_solar_current <= '0;
    end else if (item_xfer) begin
      prev_solar_voltage <= solar_voltage;
      prev_solar_current <= solar_current;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      s1_vs  <= solar_voltage;
      s1_is  <= solar_current;
      s1_vb  <= battery_voltage;
      s1_ib  <= battery_current;
      s1_pvs <= prev_solar_voltage;
      s1_pis <= prev_solar_current;
    end
  end

  // stage 1: differences, cross products, compares, target steps
  function automatic logic signed [SP-1:0] cap_step(input logic signed [W:0] err);
    logic signed [SP-1:0] r;
    if (err > $signed((W + 1)'(smcc_pkg::STEP_CAP))) begin
      r = SP'(smcc_pkg::STEP_CAP);
    end else if (err < -$signed((W + 1)'(smcc_pkg::STEP_CAP))) begin
      r = -SP'(smcc_pkg::STEP_CAP);
    end else begin
      r = err[SP-1:0];
    end
    return r;
  endfunction

  logic signed [W:0]    dv, di;
  logic signed [PW-1:0] prod_div, prod_idv;
  smcc_pkg::cmp_t       cmp_next;

  always_comb begin
    dv       = $signed({1'b0, s1_vs}) - $signed({1'b0, s1_pvs});
    di       = $signed({1'b0, s1_is}) - $signed({1'b0, s1_pis});
    prod_div = PW'(di * $signed({1'b0, s1_vs}));
    prod_idv = PW'($signed({1'b0, s1_is}) * dv);
    cmp_next.vb_ge_ok   = s1_vb >= vbat_ok_level;
    cmp_next.vb_lt_low  = s1_vb < vbat_low_level;
    cmp_next.vb_ge_high = s1_vb >= vbat_high_level;
    cmp_next.vs_ge_ok   = s1_vs >= vsol_ok_level;
    cmp_next.ib_lt_low  = s1_ib < ibat_low_level;
  end

  logic signed [PW-1:0] s2_prod_div, s2_prod_idv;
  logic                 s2_dv_zero, s2_dv_neg, s2_di_zero, s2_di_neg, s2_v_zero;
  logic signed [SP-1:0] s2_top_step, s2_flt_step;
  smcc_pkg::cmp_t       s2_cmp;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_prod_div <= prod_div;
      s2_prod_idv <= prod_idv;
      s2_dv_zero  <= dv == '0;
      s2_dv_neg   <= dv[W];
      s2_di_zero  <= di == '0;
      s2_di_neg   <= di[W];
      s2_v_zero   <= s1_vs == '0;
      s2_top_step <= cap_step($signed({1'b0, topping_target}) - $signed({1'b0, s1_vb}));
      s2_flt_step <= cap_step($signed({1'b0, float_target}) - $signed({1'b0, s1_vb}));
      s2_cmp      <= cmp_next;
    end
  end

  // stage 2: transition, duty step, clamp
  logic [smcc_pkg::STAGE_W-1:0] stage_reg;
  logic [DUTY_W-1:0]            duty_reg;
  logic                         pwm_on_flag, load_on_flag;
  smcc_pkg::decision_t          dec;

  smcc_ctrl u_ctrl (
    .stage (stage_reg),
    .cmp   (s2_cmp),
    .dec   (dec)
  );

  logic signed [SW-1:0] ic_sum;
  logic                 ic_step, ic_up;
  logic signed [SP-1:0] delta;
  logic signed [DW-1:0] duty_sum;
  logic [DUTY_W-1:0]    duty_next;
  logic                 hit_next, pwm_next, load_next;

  always_comb begin
    ic_sum = SW'(s2_prod_div) + SW'(s2_prod_idv);
    priority if (s2_dv_zero) begin
      ic_step = !s2_di_zero;
      ic_up   = s2_di_neg;
    end else if (s2_v_zero) begin
      ic_step = !s2_di_zero;
      ic_up   = s2_di_neg == s2_dv_neg;
    end else begin
      ic_step = ic_sum != '0;
      ic_up   = ic_sum[SW-1] == s2_dv_neg;
    end

    unique case (dec.next_stage)
      smcc_pkg::ST_MPPT:    delta = !ic_step ? '0 : (ic_up ? SP'(1) : -SP'(1));
      smcc_pkg::ST_TOPPING: delta = s2_top_step;
      smcc_pkg::ST_FLOAT:   delta = s2_flt_step;
      default:              delta = '0;
    endcase

    duty_sum  = $signed({2'b00, duty_reg}) + DW'(delta);
    duty_next = duty_reg;
    hit_next  = 1'b0;
    if (delta != '0) begin
      duty_next = duty_sum[DUTY_W-1:0];
      if (duty_sum >= $signed(DW'(DUTY_MAX))) begin
        duty_next = DUTY_W'(DUTY_MAX);
        hit_next  = 1'b1;
      end
      if (duty_sum <= $signed(DW'(DUTY_MIN))) begin
        duty_next = DUTY_W'(DUTY_MIN);
        hit_next  = 1'b1;
      end
    end

    pwm_next  = pwm_on_flag;
    load_next = load_on_flag;
    unique case (dec.act)
      smcc_pkg::ACT_LOAD_ON:  load_next = 1'b1;
      smcc_pkg::ACT_LOAD_OFF: load_next = 1'b0;
      smcc_pkg::ACT_PWM_ON:   pwm_next  = 1'b1;
      smcc_pkg::ACT_PWM_OFF:  pwm_next  = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg    <= smcc_pkg::ST_START;
      duty_reg     <= DUTY_W'(smcc_pkg::DUTY_RESET);
      pwm_on_flag  <= 1'b0;
      load_on_flag <= 1'b0;
    end else if (s2_adv) begin
      stage_reg    <= dec.next_stage;
      duty_reg     <= duty_next;
      pwm_on_flag  <= pwm_next;
      load_on_flag <= load_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      charge_stage <= dec.next_stage;
      event_code   <= dec.event_code;
      duty_count   <= duty_next;
      pwm_enabled  <= pwm_next;
      load_enabled <= load_next;
      limit_hit    <= hit_next;
    end
  end

  // checks
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (duty_count >= DUTY_W'(DUTY_MIN)) && (duty_count <= DUTY_W'(DUTY_MAX)))
    else $error("duty outside its range");

  a_hit_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && limit_hit) |->
      (duty_count == DUTY_W'(DUTY_MAX)) || (duty_count == DUTY_W'(DUTY_MIN)))
    else $error("limit flag without duty at a limit");

  a_capture: assert property (@(posedge clk) disable iff (rst)
    item_xfer |=> s1_valid)
    else $error("accepted item not captured");

  a_state_mirror: assert property (@(posedge clk) disable iff (rst)
    s2_adv |=> (charge_stage == stage_reg) && (duty_count == duty_reg))
    else $error("result does not match controller state");

endmodule
`default_nettype wire

// ===== rtl/core/smcc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smcc_ctrl: event choice and stage transition
// Picks the event of the current stage from the threshold compares and
// looks up the action and the next stage.
// ----------------------------------------------------------------------------
module smcc_ctrl (
  input  logic [smcc_pkg::STAGE_W-1:0] stage,
  input  smcc_pkg::cmp_t               cmp,
  output smcc_pkg::decision_t          dec
);

  logic [smcc_pkg::EVENT_W-1:0] ev;

  always_comb begin
    ev = smcc_pkg::EV_NONE;
    unique case (stage)
      smcc_pkg::ST_START: begin
        priority if (cmp.vb_ge_ok) ev = smcc_pkg::EV_VBAT_OK;
        else if (cmp.vs_ge_ok)     ev = smcc_pkg::EV_VSOL_OK;
      end
      smcc_pkg::ST_IDLE: begin
        priority if (cmp.vb_lt_low) ev = smcc_pkg::EV_VBAT_LOW;
        else if (cmp.vs_ge_ok)      ev = smcc_pkg::EV_VSOL_OK;
      end
      smcc_pkg::ST_MPPT: begin
        priority if (cmp.vb_ge_high) ev = smcc_pkg::EV_VBAT_HIGH;
        else if (!cmp.vs_ge_ok)      ev = smcc_pkg::EV_VSOL_LOW;
        else if (cmp.vb_ge_ok)       ev = smcc_pkg::EV_VBAT_OK;
        else if (cmp.vb_lt_low)      ev = smcc_pkg::EV_VBAT_LOW;
      end
      smcc_pkg::ST_TOPPING: begin
        priority if (cmp.ib_lt_low) ev = smcc_pkg::EV_IBAT_LOW;
        else if (!cmp.vs_ge_ok)     ev = smcc_pkg::EV_VSOL_LOW;
        else if (cmp.vb_lt_low)     ev = smcc_pkg::EV_VBAT_LOW;
      end
      smcc_pkg::ST_FLOAT: begin
        priority if (cmp.vb_lt_low) ev = smcc_pkg::EV_VBAT_LOW;
        else if (!cmp.vs_ge_ok)     ev = smcc_pkg::EV_VSOL_LOW;
      end
      default: ev = smcc_pkg::EV_NONE;
    endcase
  end

  always_comb begin
    dec.event_code = ev;
    {dec.act, dec.next_stage} = smcc_pkg::table_cell(stage, ev);
  end

endmodule
`default_nettype wire

// ===== tb/charge_step_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// charge_step_checker: result predictor and comparator for the charge unit
// Watches the item, result and register write channels. Keeps its own copy
// of the stage, duty, enable flags, previous solar sample and thresholds,
// predicts one result per item transfer and compares each result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module charge_step_checker #(
  parameter int SW     = smcc_pkg::SAMPLE_BITS_DEF,
  parameter int DUTY_W = $clog2(smcc_pkg::DUTY_MAX_DEF + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_ready,
  input  logic [SW-1:0]                   solar_voltage,
  input  logic [SW-1:0]                   solar_current,
  input  logic [SW-1:0]                   battery_voltage,
  input  logic [SW-1:0]                   battery_current,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  logic [smcc_pkg::STAGE_W-1:0]    charge_stage,
  input  logic [smcc_pkg::EVENT_W-1:0]    event_code,
  input  logic [DUTY_W-1:0]               duty_count,
  input  logic                            pwm_enabled,
  input  logic                            load_enabled,
  input  logic                            limit_hit,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [smcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [SW-1:0]                   cfg_data,
  output int                              error_count,
  output int                              pending
);

  import smcc_pkg::*;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic [EVENT_W-1:0] ev;
    logic [DUTY_W-1:0]  duty;
    logic               pwm;
    logic               load;
    logic               hit;
  } charge_step_t;

  charge_step_t expected_steps[$];

  logic [SW-1:0]      vsol_ok_lvl, vbat_low_lvl, vbat_ok_lvl, vbat_high_lvl;
  logic [SW-1:0]      topping_goal, float_goal, ibat_low_lvl;
  logic [STAGE_W-1:0] stage_q;
  int                 duty_q;
  logic               pwm_q, load_q;
  logic [SW-1:0]      prev_v, prev_i;

  function automatic logic step_duty(input int delta);
    int  next_duty;
    logic hit;
    next_duty = duty_q + delta;
    hit = 1'b0;
    if (next_duty >= DUTY_MAX_DEF) begin
      next_duty = DUTY_MAX_DEF;
      hit = 1'b1;
    end
    if (next_duty <= DUTY_MIN_DEF) begin
      next_duty = DUTY_MIN_DEF;
      hit = 1'b1;
    end
    duty_q = next_duty;
    return hit;
  endfunction

  // dI/dV against -I/V, compared without division
  function automatic logic conductance_step(input logic [SW-1:0] v, input logic [SW-1:0] i);
    longint dv, di, balance;
    dv = longint'(v) - longint'(prev_v);
    di = longint'(i) - longint'(prev_i);
    if (dv == 0) begin
      if (di == 0) return 1'b0;
      return step_duty(di > 0 ? -1 : 1);
    end
    if (v == 0) balance = di;
    else balance = di * longint'(v) + longint'(i) * dv;
    if (balance == 0) return 1'b0;
    return step_duty(((balance > 0) == (dv > 0)) ? 1 : -1);
  endfunction

  function automatic logic track_level(input logic [SW-1:0] goal, input logic [SW-1:0] vb);
    int err;
    err = int'(goal) - int'(vb);
    if (err == 0) return 1'b0;
    if (err > STEP_CAP) err = STEP_CAP;
    if (err < -STEP_CAP) err = -STEP_CAP;
    return step_duty(err);
  endfunction

  function automatic charge_step_t predict_charge_step(
    input logic [SW-1:0] vs,
    input logic [SW-1:0] is,
    input logic [SW-1:0] vb,
    input logic [SW-1:0] ib
  );
    charge_step_t       r;
    logic [EVENT_W-1:0] ev;
    logic [ACT_W-1:0]   act;
    logic [STAGE_W-1:0] nxt;
    logic               hit;
    ev = EV_NONE;
    case (stage_q)
      ST_START: begin
        if (vb >= vbat_ok_lvl) ev = EV_VBAT_OK;
        else if (vs >= vsol_ok_lvl) ev = EV_VSOL_OK;
      end
      ST_IDLE: begin
        if (vb < vbat_low_lvl) ev = EV_VBAT_LOW;
        else if (vs >= vsol_ok_lvl) ev = EV_VSOL_OK;
      end
      ST_MPPT: begin
        if (vb >= vbat_high_lvl) ev = EV_VBAT_HIGH;
        else if (vs < vsol_ok_lvl) ev = EV_VSOL_LOW;
        else if (vb >= vbat_ok_lvl) ev = EV_VBAT_OK;
        else if (vb < vbat_low_lvl) ev = EV_VBAT_LOW;
      end
      ST_TOPPING: begin
        if (ib < ibat_low_lvl) ev = EV_IBAT_LOW;
        else if (vs < vsol_ok_lvl) ev = EV_VSOL_LOW;
        else if (vb < vbat_low_lvl) ev = EV_VBAT_LOW;
      end
      ST_FLOAT: begin
        if (vb < vbat_low_lvl) ev = EV_VBAT_LOW;
        else if (vs < vsol_ok_lvl) ev = EV_VSOL_LOW;
      end
      default: ;
    endcase

    act = ACT_NONE;
    nxt = stage_q;
    case (stage_q)
      ST_START: begin
        if (ev == EV_VBAT_OK) begin
          act = ACT_LOAD_ON;
          nxt = ST_IDLE;
        end else if (ev == EV_VSOL_OK) begin
          act = ACT_PWM_ON;
          nxt = ST_MPPT;
        end
      end
      ST_IDLE: begin
        if (ev == EV_VBAT_LOW) begin
          act = ACT_LOAD_OFF;
          nxt = ST_START;
        end else if (ev == EV_VSOL_OK) begin
          act = ACT_PWM_ON;
          nxt = ST_MPPT;
        end
      end
      ST_MPPT: begin
        case (ev)
          EV_VBAT_LOW:  act = ACT_LOAD_OFF;
          EV_VBAT_OK:   act = ACT_LOAD_ON;
          EV_VBAT_HIGH: nxt = ST_TOPPING;
          EV_VSOL_LOW: begin
            act = ACT_PWM_OFF;
            nxt = ST_IDLE;
          end
          default: ;
        endcase
      end
      ST_TOPPING, ST_FLOAT: begin
        case (ev)
          EV_VBAT_LOW: begin
            act = ACT_LOAD_OFF;
            nxt = ST_MPPT;
          end
          EV_VSOL_LOW: begin
            act = ACT_PWM_OFF;
            nxt = ST_IDLE;
          end
          EV_IBAT_LOW: nxt = ST_FLOAT;
          default: ;
        endcase
      end
      default: nxt = ST_START;
    endcase

    case (act)
      ACT_LOAD_ON:  load_q = 1'b1;
      ACT_LOAD_OFF: load_q = 1'b0;
      ACT_PWM_ON:   pwm_q = 1'b1;
      ACT_PWM_OFF:  pwm_q = 1'b0;
      default: ;
    endcase
    stage_q = nxt;

    hit = 1'b0;
    if (stage_q == ST_MPPT) hit = conductance_step(vs, is);
    else if (stage_q == ST_TOPPING) hit = track_level(topping_goal, vb);
    else if (stage_q == ST_FLOAT) hit = track_level(float_goal, vb);

    prev_v = vs;
    prev_i = is;

    r.stage = stage_q;
    r.ev    = ev;
    r.duty  = duty_q[DUTY_W-1:0];
    r.pwm   = pwm_q;
    r.load  = load_q;
    r.hit   = hit;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    charge_step_t want;
    if (rst) begin
      vsol_ok_lvl   = VSOL_OK_RESET;
      vbat_low_lvl  = VBAT_LOW_RESET;
      vbat_ok_lvl   = VBAT_OK_RESET;
      vbat_high_lvl = VBAT_HIGH_RESET;
      topping_goal  = TOP_TGT_RESET;
      float_goal    = FLT_TGT_RESET;
      ibat_low_lvl  = IBAT_LOW_RESET;
      stage_q       = ST_START;
      duty_q        = DUTY_RESET;
      pwm_q         = 1'b0;
      load_q        = 1'b0;
      prev_v        = '0;
      prev_i        = '0;
      error_count   = 0;
      expected_steps.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_steps.size() == 0) begin
          $error("result transfer with no item outstanding: stage %0d event %0d duty %0d",
                 charge_stage, event_code, duty_count);
          error_count++;
        end else begin
          want = expected_steps.pop_front();
          check_field("charge_stage", want.stage, charge_stage);
          check_field("event_code", want.ev, event_code);
          check_field("duty_count", want.duty, duty_count);
          check_field("pwm_enabled", want.pwm, pwm_enabled);
          check_field("load_enabled", want.load, load_enabled);
          check_field("limit_hit", want.hit, limit_hit);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VSOL_OK:   vsol_ok_lvl   = cfg_data;
          REG_VBAT_LOW:  vbat_low_lvl  = cfg_data;
          REG_VBAT_OK:   vbat_ok_lvl   = cfg_data;
          REG_VBAT_HIGH: vbat_high_lvl = cfg_data;
          REG_TOP_TGT:   topping_goal  = cfg_data;
          REG_FLT_TGT:   float_goal    = cfg_data;
          REG_IBAT_LOW:  ibat_low_lvl  = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready)
        expected_steps.push_back(predict_charge_step(solar_voltage, solar_current,
                                                     battery_voltage, battery_current));
    end
    pending = expected_steps.size();
  end

endmodule

// ===== tb/solar_mppt_charge_controller_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// solar_mppt_charge_controller_unit_test: regression of the charge unit
// Drives measurement sets through every stage with directed items, then
// shaped random items under several threshold settings, with random gaps
// and stalls on both channels, a long result hold-off and drain pauses.
// The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module solar_mppt_charge_controller_unit_test;

  import smcc_pkg::*;

  localparam int SW          = SAMPLE_BITS_DEF;
  localparam int SMAX        = (1 << SW) - 1;
  localparam int DUTY_W      = $clog2(DUTY_MAX_DEF + 1);
  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD   = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic [SW-1:0]        solar_voltage = '0;
  logic [SW-1:0]        solar_current = '0;
  logic [SW-1:0]        battery_voltage = '0;
  logic [SW-1:0]        battery_current = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [STAGE_W-1:0]   charge_stage;
  logic [EVENT_W-1:0]   event_code;
  logic [DUTY_W-1:0]    duty_count;
  logic                 pwm_enabled;
  logic                 load_enabled;
  logic                 limit_hit;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VSOL_OK;
  logic [SW-1:0]        cfg_data = '0;

  int mismatches;
  int outstanding;
  int quiet = 0;

  bit send_idle = 1'b1;
  bit ready_idle = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;

  logic [SW-1:0] cfg_level [8];
  logic [SW-1:0] last_vs = '0;
  logic [SW-1:0] last_is = '0;
  int            panel_v = 2000;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  solar_mppt_charge_controller_unit dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .solar_voltage   (solar_voltage),
    .solar_current   (solar_current),
    .battery_voltage (battery_voltage),
    .battery_current (battery_current),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .charge_stage    (charge_stage),
    .event_code      (event_code),
    .duty_count      (duty_count),
    .pwm_enabled     (pwm_enabled),
    .load_enabled    (load_enabled),
    .limit_hit       (limit_hit),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  charge_step_checker #(.SW(SW), .DUTY_W(DUTY_W)) step_check (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .solar_voltage   (solar_voltage),
    .solar_current   (solar_current),
    .battery_voltage (battery_voltage),
    .battery_current (battery_current),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .charge_stage    (charge_stage),
    .event_code      (event_code),
    .duty_count      (duty_count),
    .pwm_enabled     (pwm_enabled),
    .load_enabled    (load_enabled),
    .limit_hit       (limit_hit),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (mismatches),
    .pending         (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("solar_mppt_charge_controller_unit regression: fail");
      $finish;
    end
  end

  // result side: random stall per transfer, one long hold-off on request
  initial begin : result_drain
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_served != hold_requests) begin
        holds_served++;
        result_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = ready_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  function automatic logic [SW-1:0] jitter_around(input int lvl, input int spread);
    int x;
    x = lvl + $urandom_range(0, 2 * spread) - spread;
    if (x < 0) x = 0;
    if (x > SMAX) x = SMAX;
    return x[SW-1:0];
  endfunction

  task automatic offer_item(input logic [SW-1:0] vs, input logic [SW-1:0] is,
                            input logic [SW-1:0] vb, input logic [SW-1:0] ib);
    int gap;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    solar_voltage   = vs;
    solar_current   = is;
    battery_voltage = vb;
    battery_current = ib;
    item_valid      = 1'b1;
    last_vs         = vs;
    last_is         = is;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  // drop valid, wait out every outstanding result plus the pipeline depth
  task automatic settle();
    item_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_index = idx;
    cfg_data  = val[SW-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_level[idx] = val[SW-1:0];
  endtask

  task automatic load_levels(input int vsol_ok, input int vb_low, input int vb_ok,
                             input int vb_high, input int top_goal, input int flt_goal,
                             input int ib_low);
    int center;
    settle();
    write_level(REG_VSOL_OK, vsol_ok);
    write_level(REG_VBAT_LOW, vb_low);
    write_level(REG_VBAT_OK, vb_ok);
    write_level(REG_VBAT_HIGH, vb_high);
    write_level(REG_TOP_TGT, top_goal);
    write_level(REG_FLT_TGT, flt_goal);
    write_level(REG_IBAT_LOW, ib_low);
    write_level(REG_SPARE, $urandom_range(0, SMAX));
    cfg_valid = 1'b0;
    center = vsol_ok + 800;
    panel_v = (center > SMAX) ? SMAX : center;
  endtask

  task automatic offer_random();
    logic [SW-1:0] vs, is, vb, ib;
    if ($urandom_range(0, 9) == 0) begin
      vs = $urandom_range(0, SMAX);
      is = $urandom_range(0, SMAX);
      vb = $urandom_range(0, SMAX);
      ib = $urandom_range(0, SMAX);
    end else begin
      case ($urandom_range(0, 9))
        0:       vs = jitter_around(cfg_level[REG_VSOL_OK], 8);
        1, 2:    vs = last_vs;
        default: vs = jitter_around(panel_v, 40);
      endcase
      is = ($urandom_range(0, 4) == 0) ? last_is : jitter_around(1000, 60);
      case ($urandom_range(0, 6))
        0:       vb = jitter_around(cfg_level[REG_VBAT_LOW], 6);
        1:       vb = jitter_around(cfg_level[REG_VBAT_OK], 6);
        2:       vb = jitter_around(cfg_level[REG_VBAT_HIGH], 6);
        3:       vb = jitter_around(cfg_level[REG_TOP_TGT], 70);
        4:       vb = jitter_around(cfg_level[REG_FLT_TGT], 70);
        default: vb = $urandom_range(0, SMAX);
      endcase
      if ($urandom_range(0, 3) == 0) ib = jitter_around(cfg_level[REG_IBAT_LOW], 10);
      else ib = jitter_around(cfg_level[REG_IBAT_LOW] + 200, 150);
    end
    offer_item(vs, is, vb, ib);
  endtask

  task automatic run_phase(input int count, input bit idle_send, input bit idle_recv);
    send_idle  = idle_send;
    ready_idle = idle_recv;
    repeat (count / 2) offer_random();
    if ($urandom_range(0, 1) == 1) settle();
    repeat (count - count / 2) offer_random();
  endtask

  // walk every stage and transition under the reset thresholds
  task automatic run_directed();
    offer_item(12'd0,    12'd0,    12'd0,    12'd0);
    offer_item(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    offer_item(12'd4095, 12'd4095, 12'd0,    12'd0);
    offer_item(12'd2000, 12'd1000, 12'd3300, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd3300, 12'd500);
    offer_item(12'd2000, 12'd1200, 12'd3300, 12'd500);
    offer_item(12'd2000, 12'd1100, 12'd3300, 12'd500);
    offer_item(12'd2100, 12'd950,  12'd3500, 12'd500);
    offer_item(12'd2100, 12'd950,  12'd3100, 12'd500);
    // conductance exactly balanced: no step
    offer_item(12'd2000, 12'd1000, 12'd3300, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd4095, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd3900, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd3916, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd3800, 12'd0);
    offer_item(12'd2000, 12'd1000, 12'd3723, 12'd0);
    // zero solar voltage on re-entry to tracking
    offer_item(12'd0,    12'd300,  12'd3000, 12'd0);
    offer_item(12'd2000, 12'd1000, 12'd4095, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd3000, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd4095, 12'd500);
    offer_item(12'd100,  12'd1000, 12'd3500, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd3300, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd4095, 12'd500);
    offer_item(12'd2000, 12'd1000, 12'd3800, 12'd0);
    offer_item(12'd100,  12'd1000, 12'd3800, 12'd0);
    offer_item(12'd2000, 12'd1000, 12'd3300, 12'd500);
    offer_item(12'd100,  12'd1000, 12'd3300, 12'd500);
  endtask

  initial begin : stimulus
    int lo, ok, hi;
    cfg_level[REG_VSOL_OK]   = VSOL_OK_RESET;
    cfg_level[REG_VBAT_LOW]  = VBAT_LOW_RESET;
    cfg_level[REG_VBAT_OK]   = VBAT_OK_RESET;
    cfg_level[REG_VBAT_HIGH] = VBAT_HIGH_RESET;
    cfg_level[REG_TOP_TGT]   = TOP_TGT_RESET;
    cfg_level[REG_FLT_TGT]   = FLT_TGT_RESET;
    cfg_level[REG_IBAT_LOW]  = IBAT_LOW_RESET;
    cfg_level[REG_SPARE]     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_phase(200, 1'b1, 1'b1);

    // hold results off while items keep coming, then drain
    hold_requests++;
    send_idle = 1'b0;
    repeat (40) offer_random();
    settle();

    load_levels(VSOL_OK_RESET, VBAT_LOW_RESET, VBAT_OK_RESET, VBAT_HIGH_RESET,
                TOP_TGT_RESET, FLT_TGT_RESET, IBAT_LOW_RESET);
    run_phase(150, 1'b0, 1'b0);

    repeat (2) begin
      lo = $urandom_range(1000, 2500);
      ok = lo + $urandom_range(0, 600);
      hi = ok + $urandom_range(0, 800);
      load_levels($urandom_range(0, 3000), lo, ok, hi, $urandom_range(ok, hi),
                  $urandom_range(lo, ok), $urandom_range(0, 500));
      run_phase(120, $urandom_range(0, 1), $urandom_range(0, 1));
    end

    load_levels(0, 0, 0, 0, 0, 0, 0);
    run_phase(100, 1'b1, 1'b1);
    load_levels(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
    run_phase(100, 1'b1, 1'b0);
    load_levels(VSOL_OK_RESET, VBAT_LOW_RESET, VBAT_OK_RESET, VBAT_HIGH_RESET,
                SMAX, SMAX, IBAT_LOW_RESET);
    run_phase(150, 1'b0, 1'b1);
    load_levels(VSOL_OK_RESET, VBAT_LOW_RESET, VBAT_OK_RESET, VBAT_HIGH_RESET,
                0, 0, IBAT_LOW_RESET);
    run_phase(150, 1'b1, 1'b1);

    repeat (3) begin
      load_levels($urandom_range(0, SMAX), $urandom_range(0, SMAX), $urandom_range(0, SMAX),
                  $urandom_range(0, SMAX), $urandom_range(0, SMAX), $urandom_range(0, SMAX),
                  $urandom_range(0, SMAX));
      run_phase(100, $urandom_range(0, 1), 1'b1);
    end

    load_levels(VSOL_OK_RESET, VBAT_LOW_RESET, VBAT_OK_RESET, VBAT_HIGH_RESET,
                TOP_TGT_RESET, FLT_TGT_RESET, IBAT_LOW_RESET);
    run_phase(250, 1'b1, 1'b1);
    settle();

    if (mismatches == 0 && outstanding == 0)
      $display("solar_mppt_charge_controller_unit regression: pass");
    else
      $display("solar_mppt_charge_controller_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/smcc_pkg.sv
rtl/core/smcc_ctrl.sv
rtl/core/solar_mppt_charge_controller_unit.sv
tb/charge_step_checker.sv
tb/solar_mppt_charge_controller_unit_test.sv
